>>> rtl/message_type_acceptance_filter_core_assert.svh
// Assertion macros used by the checker file.
`ifndef MESSAGE_TYPE_ACCEPTANCE_FILTER_CORE_ASSERT_SVH
`define MESSAGE_TYPE_ACCEPTANCE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MTAF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MTAF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mtaf_pkg.sv
package mtaf_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Field widths.
   localparam int TYPE_ID_W = 16;
   localparam int KIND_W = 2;
   localparam int KEY_W = TYPE_ID_W + KIND_W;
   localparam int SIG_W = 64;
   localparam int HANDLER_W = 8;

   // Item modes.
   typedef enum logic [1:0] {
      MODE_INSERT   = 2'd0,
      MODE_ACCEPT   = 2'd1,
      MODE_DISPATCH = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   // Transfer kinds.
   localparam logic [KIND_W-1:0] KIND_RESPONSE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BROADCAST = 2'd2;

   typedef logic [KEY_W-1:0] key_type;

   // Write request into the handler table.
   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     addr;
      key_type              key;
      logic [SIG_W-1:0]     signature;
      logic [HANDLER_W-1:0] handler;
   } tbl_wr_type;

endpackage

>>> rtl/mtaf_if.sv
// Request channel: one word per filter operation.
interface mtaf_req_if
   import mtaf_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [TYPE_ID_W-1:0] type_id;
   logic [KIND_W-1:0]    xfer_kind;
   logic [SIG_W-1:0]     entry_signature;
   logic [HANDLER_W-1:0] handler_num;

   modport source (output valid, mode, type_id, xfer_kind, entry_signature, handler_num,
                   input ready);
   modport sink (input valid, mode, type_id, xfer_kind, entry_signature, handler_num,
                 output ready);
endinterface

// Response channel: one word per result.
interface mtaf_rsp_if
   import mtaf_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 matched;
   logic                 table_full;
   logic [SIG_W-1:0]     found_signature;
   logic [HANDLER_W-1:0] found_handler;
   logic                 last;

   modport source (output valid, matched, table_full, found_signature, found_handler, last,
                   input ready);
   modport sink (input valid, matched, table_full, found_signature, found_handler, last,
                 output ready);
endinterface

>>> rtl/message_type_acceptance_filter_core.sv
// Message type acceptance filter. The block holds a table of up to 16 handler entries,
// each keyed by a 16-bit data type id and a 2-bit transfer kind, with a 64-bit signature
// and an 8-bit handler number. A request word either appends an entry (insert), asks
// whether a key is known and returns the newest signature (accept), or lists matching
// handler numbers newest first (dispatch: every match for a broadcast, only the newest
// for any other transfer kind). Every request yields at least one response word, and
// the last one carries last=1. Accept and dispatch walk the table from the newest entry
// down through one key comparator, one entry per cycle while no match waits for the
// output register. A new request is taken only once the previous one has finished,
// while its final response word may still be waiting in the output register.
module message_type_acceptance_filter_core
   import mtaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mtaf_req_if.sink    req_ch,
   mtaf_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   key_type              key_ff, key_in;
   logic                 service_ff, service_in;
   logic                 ins_ok_ff, ins_ok_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [HANDLER_W-1:0] pend_handler_ff, pend_handler_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic [SIG_W-1:0]     rsp_sig_ff, rsp_sig_in;
   logic [HANDLER_W-1:0] rsp_handler_ff, rsp_handler_in;
   logic                 rsp_last_ff, rsp_last_in;

   tbl_wr_type           tbl_wr;
   logic [CNT_W-1:0]     rd_idx;
   logic                 hit;
   logic [SIG_W-1:0]     rd_signature;
   logic [HANDLER_W-1:0] rd_handler;
   logic                 slot_free;
   logic                 load;
   logic                 req_take;

   // The scan index counts entries still to check; the entry read is one below it.
   assign rd_idx = idx_ff - CNT_W'(1);

   mtaf_table u_table (
      .clock        (clock),
      .wr           (tbl_wr),
      .rd_addr      (rd_idx[IDX_W-1:0]),
      .match_key    (key_ff),
      .hit          (hit),
      .rd_signature (rd_signature),
      .rd_handler   (rd_handler)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   // The output register can take a new word when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer next-state and output word selection.
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      key_in          = key_ff;
      service_in      = service_ff;
      ins_ok_in       = ins_ok_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      pend_valid_in   = pend_valid_ff;
      pend_handler_in = pend_handler_ff;
      load            = 1'b0;
      rsp_matched_in  = 1'b0;
      rsp_full_in     = 1'b0;
      rsp_sig_in      = '0;
      rsp_handler_in  = '0;
      rsp_last_in     = 1'b1;
      tbl_wr.en        = 1'b0;
      tbl_wr.addr      = count_ff[IDX_W-1:0];
      tbl_wr.key       = {req_ch.type_id, req_ch.xfer_kind};
      tbl_wr.signature = req_ch.entry_signature;
      tbl_wr.handler   = req_ch.handler_num;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in       = mode_type'(req_ch.mode);
               key_in        = {req_ch.type_id, req_ch.xfer_kind};
               service_in    = (req_ch.xfer_kind != KIND_BROADCAST);
               ins_ok_in     = (count_ff < CNT_W'(TABLE_DEPTH));
               idx_in        = count_ff;
               pend_valid_in = 1'b0;
               if (mode_type'(req_ch.mode) == MODE_INSERT &&
                   count_ff < CNT_W'(TABLE_DEPTH)) begin
                  tbl_wr.en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               if (mode_type'(req_ch.mode) == MODE_ACCEPT ||
                   mode_type'(req_ch.mode) == MODE_DISPATCH) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            if (idx_ff == '0) begin
               state_in = ST_FINISH;
            end else if (!hit) begin
               idx_in = rd_idx;
            end else if (mode_ff == MODE_ACCEPT) begin
               // Newest match ends an accept at once.
               if (slot_free) begin
                  load           = 1'b1;
                  rsp_matched_in = 1'b1;
                  rsp_sig_in     = rd_signature;
                  state_in       = ST_IDLE;
               end
            end else if (service_ff) begin
               // Service transfers deliver only the newest handler.
               if (slot_free) begin
                  load           = 1'b1;
                  rsp_matched_in = 1'b1;
                  rsp_handler_in = rd_handler;
                  state_in       = ST_IDLE;
               end
            end else if (pend_valid_ff) begin
               // A later match proves the held handler is not the final word.
               if (slot_free) begin
                  load            = 1'b1;
                  rsp_matched_in  = 1'b1;
                  rsp_handler_in  = pend_handler_ff;
                  rsp_last_in     = 1'b0;
                  pend_handler_in = rd_handler;
                  idx_in          = rd_idx;
               end
            end else begin
               pend_valid_in   = 1'b1;
               pend_handler_in = rd_handler;
               idx_in          = rd_idx;
            end
         end

         ST_FINISH: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               case (mode_ff)
                  MODE_INSERT: begin
                     rsp_matched_in = ins_ok_ff;
                     rsp_full_in    = !ins_ok_ff;
                  end
                  MODE_DISPATCH: begin
                     rsp_matched_in = pend_valid_ff;
                     rsp_handler_in = pend_valid_ff ? pend_handler_ff : '0;
                  end
                  default: begin
                     rsp_matched_in = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State, scan registers and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff         <= mode_in;
      key_ff          <= key_in;
      service_ff      <= service_in;
      ins_ok_ff       <= ins_ok_in;
      idx_ff          <= idx_in;
      pend_handler_ff <= pend_handler_in;
      if (load) begin
         rsp_matched_ff <= rsp_matched_in;
         rsp_full_ff    <= rsp_full_in;
         rsp_sig_ff     <= rsp_sig_in;
         rsp_handler_ff <= rsp_handler_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.matched         = rsp_matched_ff;
   assign rsp_ch.table_full      = rsp_full_ff;
   assign rsp_ch.found_signature = rsp_sig_ff;
   assign rsp_ch.found_handler   = rsp_handler_ff;
   assign rsp_ch.last            = rsp_last_ff;

endmodule

>>> rtl/mtaf_table.sv
// Handler table with one write port, one read port and the shared key comparator.
module mtaf_table
   import mtaf_pkg::*;
(
   input  logic                 clock,
   input  tbl_wr_type           wr,
   input  logic [IDX_W-1:0]     rd_addr,
   input  key_type              match_key,
   output logic                 hit,
   output logic [SIG_W-1:0]     rd_signature,
   output logic [HANDLER_W-1:0] rd_handler
);

   key_type              key_mem [TABLE_DEPTH];
   logic [SIG_W-1:0]     sig_mem [TABLE_DEPTH];
   logic [HANDLER_W-1:0] hnd_mem [TABLE_DEPTH];

   // Entries are only appended; contents need no reset.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.key;
         sig_mem[wr.addr] <= wr.signature;
         hnd_mem[wr.addr] <= wr.handler;
      end
   end

   // One entry is examined per cycle by a single comparator.
   assign hit          = (key_mem[rd_addr] == match_key);
   assign rd_signature = sig_mem[rd_addr];
   assign rd_handler   = hnd_mem[rd_addr];

endmodule

>>> rtl/mtaf_checker.sv
`include "message_type_acceptance_filter_core_assert.svh"

// Port-level checks on the acceptance filter.
module mtaf_checker
   import mtaf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_matched,
   input logic                 rsp_full,
   input logic [SIG_W-1:0]     rsp_sig,
   input logic [HANDLER_W-1:0] rsp_handler,
   input logic                 rsp_last
);

   // A stalled response word stays offered.
   `MTAF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response word dropped")

   // A stalled response word keeps its payload.
   `MTAF_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_sig) && $stable(rsp_handler) && $stable(rsp_last), "response payload changed while stalled")

   // The filter works on one request at a time.
   `MTAF_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

   // Only broadcast dispatch produces non-final words, and each is a handler match.
   `MTAF_ASSERT_NOW(a_mid_word, rsp_valid && !rsp_last, rsp_matched && !rsp_full && rsp_sig == '0, "bad non-final response word")

   // A refused insert never reports a match and ends the request.
   `MTAF_ASSERT_NOW(a_full_word, rsp_valid && rsp_full, !rsp_matched && rsp_last && rsp_handler == '0, "bad table full response")

endmodule

bind message_type_acceptance_filter_core mtaf_checker u_mtaf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_matched (rsp_ch.matched),
   .rsp_full    (rsp_ch.table_full),
   .rsp_sig     (rsp_ch.found_signature),
   .rsp_handler (rsp_ch.found_handler),
   .rsp_last    (rsp_ch.last)
);

>>> bench/testbench.sv
module testbench
   import mtaf_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;

   // One request word as the sender sees it.
   typedef struct packed {
      mode_type             mode;
      logic [TYPE_ID_W-1:0] type_id;
      logic [KIND_W-1:0]    xfer_kind;
      logic [SIG_W-1:0]     entry_signature;
      logic [HANDLER_W-1:0] handler_num;
   } request_word_type;

   // One response word as the receiver sees it.
   typedef struct packed {
      logic                 matched;
      logic                 table_full;
      logic [SIG_W-1:0]     found_signature;
      logic [HANDLER_W-1:0] found_handler;
      logic                 last;
   } response_word_type;

   // Mirror of the handler table. It turns each accepted request into the
   // response words the filter must return, and checks them in order.
   class handler_table_tracker;
      key_type              keys[TABLE_DEPTH];
      logic [SIG_W-1:0]     signatures[TABLE_DEPTH];
      logic [HANDLER_W-1:0] handlers[TABLE_DEPTH];
      int unsigned          fill;
      response_word_type    expected_words[$];
      int unsigned          errors;

      function new();
         fill = 0;
         errors = 0;
      endfunction

      function void note_request(request_word_type w);
         key_type           key;
         int unsigned       hits;
         response_word_type r;
         key = {w.type_id, w.xfer_kind};
         r = '0;
         r.last = 1'b1;
         hits = 0;
         case (w.mode)
            MODE_INSERT: begin
               // Append while there is room; a full table refuses the entry.
               if (fill < TABLE_DEPTH) begin
                  keys[fill] = key;
                  signatures[fill] = w.entry_signature;
                  handlers[fill] = w.handler_num;
                  fill++;
                  r.matched = 1'b1;
               end else begin
                  r.table_full = 1'b1;
               end
               expected_words.push_back(r);
            end
            MODE_ACCEPT: begin
               // The newest matching entry supplies the signature.
               for (int i = fill; i > 0; i--) begin
                  if (keys[i-1] == key) begin
                     r.matched = 1'b1;
                     r.found_signature = signatures[i-1];
                     break;
                  end
               end
               expected_words.push_back(r);
            end
            MODE_DISPATCH: begin
               // Broadcasts list every match newest first; service kinds stop at one.
               for (int i = fill; i > 0; i--) begin
                  if (keys[i-1] == key) begin
                     r.matched = 1'b1;
                     r.last = 1'b0;
                     r.found_handler = handlers[i-1];
                     expected_words.push_back(r);
                     hits++;
                     if (w.xfer_kind != KIND_BROADCAST) break;
                  end
               end
               if (hits == 0) begin
                  expected_words.push_back(r);
               end else begin
                  expected_words[expected_words.size()-1].last = 1'b1;
               end
            end
            default: begin
               expected_words.push_back(r);
            end
         endcase
      endfunction

      function void check_response(response_word_type got);
         response_word_type want;
         if (expected_words.size() == 0) begin
            $error("response word with nothing outstanding");
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, got.matched);
            errors++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
            errors++;
         end
         if (got.found_signature !== want.found_signature) begin
            $error("found_signature: expected %h, got %h",
                   want.found_signature, got.found_signature);
            errors++;
         end
         if (got.found_handler !== want.found_handler) begin
            $error("found_handler: expected %h, got %h", want.found_handler, got.found_handler);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mtaf_req_if req_ch();
   mtaf_rsp_if rsp_ch();

   message_type_acceptance_filter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   handler_table_tracker tracker = new();

   logic [15:0] stall_mask = '1;
   logic [7:0]  stall_phase = '0;
   int unsigned idle_cycles = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver follows a mask that is redrawn whenever the low six phase bits are zero:
   // sometimes always ready, sometimes a random or a sparse pattern.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase[5:0] == 6'd0) begin
         case ($urandom_range(0, 3))
            0, 1: stall_mask <= '1;
            2: stall_mask <= 16'($urandom);
            default: stall_mask <= 16'($urandom & $urandom);
         endcase
      end
      rsp_ch.ready <= stall_mask[stall_phase[3:0]];
   end

   // Every accepted response word goes to the checker.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_response('{rsp_ch.matched, rsp_ch.table_full, rsp_ch.found_signature,
                                  rsp_ch.found_handler, rsp_ch.last});
      end
   end

   // Give up when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   function automatic request_word_type make_word(mode_type m, logic [TYPE_ID_W-1:0] id,
                                                  logic [KIND_W-1:0] k, logic [SIG_W-1:0] s,
                                                  logic [HANDLER_W-1:0] h);
      request_word_type w;
      w.mode = m;
      w.type_id = id;
      w.xfer_kind = k;
      w.entry_signature = s;
      w.handler_num = h;
      return w;
   endfunction

   // Random words lean on a small set of ids so that lookups hit stored entries
   // and broadcasts find several matches; a few ids are drawn from the full range.
   function automatic request_word_type random_word();
      logic [TYPE_ID_W-1:0] id_pool[4];
      request_word_type     w;
      int unsigned          roll;
      id_pool = '{16'h0000, 16'hffff, 16'h0123, 16'hbeef};
      roll = $urandom_range(0, 99);
      if (roll < 10) w.mode = MODE_INSERT;
      else if (roll < 45) w.mode = MODE_ACCEPT;
      else if (roll < 95) w.mode = MODE_DISPATCH;
      else w.mode = MODE_NONE;
      if ($urandom_range(0, 3) == 0) w.type_id = 16'($urandom);
      else w.type_id = id_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 9) < 4) w.xfer_kind = KIND_BROADCAST;
      else w.xfer_kind = 2'($urandom_range(0, 3));
      w.entry_signature = {$urandom, $urandom};
      w.handler_num = 8'($urandom_range(0, 255));
      return w;
   endfunction

   // Present one word after an optional gap and hold it until it is taken.
   task automatic send_word(request_word_type w, int unsigned gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= w.mode;
      req_ch.type_id <= w.type_id;
      req_ch.xfer_kind <= w.xfer_kind;
      req_ch.entry_signature <= w.entry_signature;
      req_ch.handler_num <= w.handler_num;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(w);
   endtask

   // Hold the sender off until every outstanding response word has arrived.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.expected_words.size() != 0);
   endtask

   initial begin
      request_word_type directed[$];
      int unsigned      burst_left;
      int unsigned      gap;

      reset = 1'b1;
      rsp_ch.ready = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_NONE;
      req_ch.type_id = '0;
      req_ch.xfer_kind = '0;
      req_ch.entry_signature = '0;
      req_ch.handler_num = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Lookups on an empty table, then entries at the field extremes with
      // duplicate keys, then lookups that hit, miss and stop early.
      directed.push_back(make_word(MODE_ACCEPT, 16'h0000, KIND_RESPONSE, '1, 8'hff));
      directed.push_back(make_word(MODE_DISPATCH, 16'h0000, KIND_BROADCAST, '0, 8'h00));
      directed.push_back(make_word(MODE_NONE, 16'hffff, 2'd3, '1, 8'hff));
      directed.push_back(make_word(MODE_INSERT, 16'h0000, KIND_RESPONSE, '0, 8'h00));
      directed.push_back(make_word(MODE_INSERT, 16'hffff, 2'd3, '1, 8'hff));
      directed.push_back(make_word(MODE_INSERT, 16'h0000, KIND_BROADCAST,
                                   64'h5555_5555_5555_5555, 8'h55));
      directed.push_back(make_word(MODE_INSERT, 16'h0000, KIND_BROADCAST,
                                   64'haaaa_aaaa_aaaa_aaaa, 8'haa));
      directed.push_back(make_word(MODE_INSERT, 16'hffff, KIND_REQUEST,
                                   64'h0123_4567_89ab_cdef, 8'h01));
      directed.push_back(make_word(MODE_INSERT, 16'hffff, KIND_REQUEST,
                                   64'hfedc_ba98_7654_3210, 8'h02));
      directed.push_back(make_word(MODE_ACCEPT, 16'h0000, KIND_RESPONSE, '1, 8'hff));
      directed.push_back(make_word(MODE_ACCEPT, 16'hffff, 2'd3, '0, 8'h00));
      directed.push_back(make_word(MODE_ACCEPT, 16'h0000, KIND_BROADCAST, '0, 8'h00));
      directed.push_back(make_word(MODE_ACCEPT, 16'h1234, KIND_RESPONSE, '0, 8'h00));
      directed.push_back(make_word(MODE_DISPATCH, 16'h0000, KIND_BROADCAST, '1, 8'hff));
      directed.push_back(make_word(MODE_DISPATCH, 16'hffff, KIND_REQUEST, '0, 8'h00));
      directed.push_back(make_word(MODE_DISPATCH, 16'hffff, 2'd3, '0, 8'h00));
      directed.push_back(make_word(MODE_DISPATCH, 16'h0000, KIND_RESPONSE, '0, 8'h00));
      directed.push_back(make_word(MODE_DISPATCH, 16'hffff, KIND_RESPONSE, '0, 8'h00));
      directed.push_back(make_word(MODE_DISPATCH, 16'hffff, KIND_BROADCAST, '0, 8'h00));
      directed.push_back(make_word(MODE_NONE, 16'h0000, KIND_RESPONSE, '0, 8'h00));
      foreach (directed[i]) begin
         send_word(directed[i], $urandom_range(0, 2));
      end
      wait_for_drain();

      // Random traffic in bursts; the table fills partway through and later
      // inserts are refused.
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gap = 0;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         end
         burst_left--;
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         send_word(random_word(), gap);
      end
      req_ch.valid <= 1'b0;

      // Let the remaining responses come out, then allow a short settling time.
      while (tracker.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_words.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
